// File: hw/rtl/lhwf_pkg.sv
package lhwf_pkg;

	// Coordinate width used for neighbor cells, wide enough for any map side plus margin.
	localparam int CRD_W = 9;

	// Item modes carried on the input tuser.
	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_STEP    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_X        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y        = 3'd4;

	// Values after reset.
	localparam logic [4:0] RST_START_X       = 5'd1;
	localparam logic [4:0] RST_START_Y       = 5'd1;
	localparam logic [1:0] RST_START_HEADING = 2'd2;
	localparam logic [4:0] RST_GOAL_X        = 5'd17;
	localparam logic [4:0] RST_GOAL_Y        = 5'd15;
	localparam logic       RST_FRAME         = 1'b1;

	typedef struct packed {
		logic [4:0] x;
		logic [4:0] y;
		logic [1:0] heading;
		logic       frame;
	} walker_t;

	typedef struct packed {
		logic [4:0] start_x;
		logic [4:0] start_y;
		logic [1:0] start_heading;
		logic [4:0] goal_x;
		logic [4:0] goal_y;
	} cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [4:0] cell_x;
		logic [4:0] cell_y;
		logic       wall_bit;
	} item_t;

	// Single-bit write request into the wall map.
	typedef struct packed {
		logic       en;
		logic [4:0] x;
		logic [4:0] y;
		logic       wall;
	} map_wr_t;

	// Result item; the last field sits in the lowest bits.
	typedef struct packed {
		logic       arrived;
		logic [8:0] screen_y;
		logic [8:0] screen_x;
		logic [4:0] tile_base;
		logic       frame;
		logic [1:0] heading;
		logic [4:0] pos_y;
		logic [4:0] pos_x;
	} result_t;

	// Wall bits around the walker: [row][col], origin one cell up and left of the footprint.
	typedef logic [3:0][3:0] win_t;

endpackage

// File: hw/rtl/lhwf_map.sv
module lhwf_map
	import lhwf_pkg::*;
#(
	parameter int MAP_WIDTH  = 32,
	parameter int MAP_HEIGHT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  map_wr_t    wr,
	input  logic [4:0] rd_x,
	input  logic [4:0] rd_y,
	output win_t       win,
	output logic       busy
);

	localparam int COL_AW     = $clog2(MAP_WIDTH);
	localparam int BANK_ROWS  = (MAP_HEIGHT + 3) / 4;
	localparam int BANK_AW    = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
	localparam int BANK_SLOTS = 1 << BANK_AW;
	localparam logic [BANK_AW-1:0] LAST_ROW = BANK_AW'(BANK_ROWS - 1);

	// Rows are interleaved over four banks, so any four consecutive rows hit distinct banks.
	logic [MAP_WIDTH-1:0] mem [0:3][0:BANK_SLOTS-1];

	logic [CRD_W-1:0]     wx9, wy9;
	logic                 wr_hit;
	logic [1:0]           wr_bank;
	logic [BANK_AW-1:0]   wr_row;
	logic [COL_AW-1:0]    wr_col;
	logic [CRD_W-1:0]     ry9 [0:3];
	logic [BANK_AW-1:0]   rd_row [0:3];
	logic [MAP_WIDTH-1:0] rd_q [0:3];
	logic [MAP_WIDTH-1:0] row_m [0:3];
	logic [3:0]           byp_q;
	logic [COL_AW-1:0]    byp_col_q;
	logic                 byp_val_q;
	logic [4:0]           rx_q, ry_q;
	logic                 busy_q;
	logic [BANK_AW-1:0]   clr_q;

	// Write decode; cells outside the map are not stored.
	assign wx9     = CRD_W'(wr.x);
	assign wy9     = CRD_W'(wr.y);
	assign wr_hit  = wr.en && (wx9 < CRD_W'(MAP_WIDTH)) && (wy9 < CRD_W'(MAP_HEIGHT));
	assign wr_bank = wy9[1:0];
	assign wr_row  = wy9[BANK_AW+1:2];
	assign wr_col  = wx9[COL_AW-1:0];

	// Each bank fetches the one row of rd_y-1 .. rd_y+2 that it holds.
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			ry9[b] = CRD_W'(rd_y) - CRD_W'(1) + CRD_W'(2'(2'(b) - rd_y[1:0] + 2'd1));
			rd_row[b] = ry9[b][BANK_AW+1:2];
		end
	end

	// Clearing pass after reset, one row of every bank per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + BANK_AW'(1);
			if (clr_q == LAST_ROW) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;

	// Memory writes.
	always_ff @(posedge clk) begin
		for (int b = 0; b < 4; b++) begin
			if (busy_q) begin
				mem[b][clr_q] <= '0;
			end else if (wr_hit && wr_bank == 2'(b)) begin
				mem[b][wr_row][wr_col] <= wr.wall;
			end
		end
	end

	// Registered reads, with the bit written in the same cycle noted for bypass.
	always_ff @(posedge clk) begin
		for (int b = 0; b < 4; b++) begin
			rd_q[b]  <= mem[b][rd_row[b]];
			byp_q[b] <= !busy_q && wr_hit && wr_bank == 2'(b) && wr_row == rd_row[b];
		end
		byp_col_q <= wr_col;
		byp_val_q <= wr.wall;
		rx_q      <= rd_x;
		ry_q      <= rd_y;
	end

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			row_m[b] = rd_q[b];
			if (byp_q[b]) begin
				row_m[b][byp_col_q] = byp_val_q;
			end
		end
	end

	// Neighborhood window; anything outside the map reads as wall.
	always_comb begin
		logic [CRD_W-1:0] cy9;
		logic [CRD_W-1:0] cx9;
		logic             row_ok;
		logic             col_ok;
		for (int k = 0; k < 4; k++) begin
			cy9    = CRD_W'(ry_q) - CRD_W'(1) + CRD_W'(k);
			row_ok = !cy9[CRD_W-1] && (cy9 < CRD_W'(MAP_HEIGHT));
			for (int j = 0; j < 4; j++) begin
				cx9    = CRD_W'(rx_q) - CRD_W'(1) + CRD_W'(j);
				col_ok = !cx9[CRD_W-1] && (cx9 < CRD_W'(MAP_WIDTH));
				win[k][j] = !(row_ok && col_ok) || row_m[cy9[1:0]][cx9[COL_AW-1:0]];
			end
		end
	end

	// The clearing pass runs once per reset.
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> !busy_q)
		else $error("map clearing pass restarted");

	// No map write may arrive while the map is being cleared.
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !wr.en)
		else $error("map write during clearing pass");

endmodule

// File: hw/rtl/lhwf_step.sv
module lhwf_step
	import lhwf_pkg::*;
(
	input  walker_t cur,
	input  item_t   item,
	input  cfg_t    cfg,
	input  win_t    win,
	output walker_t nxt,
	output map_wr_t wr,
	output result_t res
);

	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_EAST  = 2'd1;
	localparam logic [1:0] DIR_SOUTH = 2'd2;
	localparam logic [1:0] DIR_WEST  = 2'd3;

	logic [3:0] blocked;
	logic [1:0] left_dir;
	logic       left_free;
	logic       ahead_free;
	logic [1:0] move_dir;
	logic [4:0] mx, my;

	// Side of the 2x2 footprint facing each absolute direction.
	always_comb begin
		blocked[DIR_NORTH] = win[0][1] | win[0][2];
		blocked[DIR_EAST]  = win[1][3] | win[2][3];
		blocked[DIR_SOUTH] = win[3][1] | win[3][2];
		blocked[DIR_WEST]  = win[1][0] | win[2][0];
	end

	assign left_dir   = cur.heading - 2'd1;
	assign left_free  = !blocked[left_dir];
	assign ahead_free = !blocked[cur.heading];
	assign move_dir   = left_free ? left_dir : cur.heading;

	// Position after one cell of movement; coordinates wrap in five bits.
	always_comb begin
		mx = cur.x;
		my = cur.y;
		unique case (move_dir)
			DIR_NORTH: my = cur.y - 5'd1;
			DIR_EAST:  mx = cur.x + 5'd1;
			DIR_SOUTH: my = cur.y + 5'd1;
			DIR_WEST:  mx = cur.x - 5'd1;
		endcase
	end

	// Walker update: left-hand rule on a step, start values on a restart, no change on a write.
	always_comb begin
		nxt = cur;
		unique case (item.mode)
			MODE_STEP: begin
				nxt.frame = !cur.frame;
				priority if (left_free) begin
					nxt.heading = left_dir;
					nxt.x       = mx;
					nxt.y       = my;
				end else if (ahead_free) begin
					nxt.x = mx;
					nxt.y = my;
				end else begin
					nxt.heading = cur.heading + 2'd1;
				end
			end
			MODE_RESTART: begin
				nxt.x       = cfg.start_x;
				nxt.y       = cfg.start_y;
				nxt.heading = cfg.start_heading;
			end
			default: begin
			end
		endcase
	end

	// Map write request for a write item.
	always_comb begin
		wr.en   = (item.mode == MODE_WRITE);
		wr.x    = item.cell_x;
		wr.y    = item.cell_y;
		wr.wall = item.wall_bit;
	end

	// Display data for the state after this item.
	always_comb begin
		res.pos_x     = nxt.x;
		res.pos_y     = nxt.y;
		res.heading   = nxt.heading;
		res.frame     = nxt.frame;
		res.tile_base = {nxt.heading, nxt.frame, 2'b00};
		res.screen_x  = {1'b0, nxt.x, 3'b000} + 9'd8;
		res.screen_y  = {1'b0, nxt.y, 3'b000} + 9'd16;
		res.arrived   = (nxt.x == cfg.goal_x) && (nxt.y == cfg.goal_y);
	end

endmodule

// File: hw/rtl/left_hand_wall_follower.sv
// Channel   Direction  Signals                    Transaction contents
// s_        in         tvalid tready tdata tuser  tuser: mode; tdata: cell_x, cell_y, wall_bit
// m_        out        tvalid tready tdata        tdata: pos_x .. arrived (one per input)
// cfg_      in         wen idx data               one register write per cycle
//
// One transaction per cycle while m_tready is high; results pass input and result registers.
// The walker's neighborhood is read from four row banks using the position the current item
// produces, so the next step finds its window ready in the following cycle.
// After reset the wall map is cleared with s_tready low.
// A stalled output holds its result while one further input waits in the input register.
module left_hand_wall_follower
	import lhwf_pkg::*;
#(
	parameter int MAP_WIDTH  = 32,
	parameter int MAP_HEIGHT = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // cell_x[4:0], cell_y[9:5], wall_bit[10], zero
	input  logic [1:0]            s_tuser,   // mode[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,   // pos_x, pos_y, heading, frame, tile_base,
	                                         // screen_x, screen_y, arrived[36], zero
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    vld_s1;
	logic    adv_s1;
	logic    fire_s1;
	walker_t walker_q;
	walker_t nxt;
	walker_t rd_pos;
	map_wr_t wr;
	map_wr_t map_wr;
	result_t res;
	result_t res_q;
	logic    out_vld_q;
	win_t    win;
	logic    map_busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x       <= RST_START_X;
			cfg_q.start_y       <= RST_START_Y;
			cfg_q.start_heading <= RST_START_HEADING;
			cfg_q.goal_x        <= RST_GOAL_X;
			cfg_q.goal_y        <= RST_GOAL_Y;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_START_X:       cfg_q.start_x       <= cfg_data;
				REG_START_Y:       cfg_q.start_y       <= cfg_data;
				REG_START_HEADING: cfg_q.start_heading <= cfg_data[1:0];
				REG_GOAL_X:        cfg_q.goal_x        <= cfg_data;
				REG_GOAL_Y:        cfg_q.goal_y        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Handshake: the input register advances whenever the result register is free.
	assign adv_s1   = !out_vld_q || m_tready;
	assign fire_s1  = vld_s1 && adv_s1;
	assign s_tready = !map_busy && (!vld_s1 || adv_s1);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode     <= s_tuser;
			item_s1.cell_x   <= s_tdata[4:0];
			item_s1.cell_y   <= s_tdata[9:5];
			item_s1.wall_bit <= s_tdata[10];
		end
	end

	// Walker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walker_q.x       <= RST_START_X;
			walker_q.y       <= RST_START_Y;
			walker_q.heading <= RST_START_HEADING;
			walker_q.frame   <= RST_FRAME;
		end else if (fire_s1) begin
			walker_q <= nxt;
		end
	end

	lhwf_step u_step (
		.cur  (walker_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.win  (win),
		.nxt  (nxt),
		.wr   (wr),
		.res  (res)
	);

	// The map fetches the window for the position the walker holds after this edge.
	always_comb begin
		rd_pos    = fire_s1 ? nxt : walker_q;
		map_wr    = wr;
		map_wr.en = wr.en && fire_s1;
	end

	lhwf_map #(
		.MAP_WIDTH  (MAP_WIDTH),
		.MAP_HEIGHT (MAP_HEIGHT)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (map_wr),
		.rd_x   (rd_pos.x),
		.rd_y   (rd_pos.y),
		.win    (win),
		.busy   (map_busy)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, res_q};

	// Every step flips the animation frame.
	a_step_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && item_s1.mode == MODE_STEP) |=> (walker_q.frame != $past(walker_q.frame)))
		else $error("step did not toggle the frame");

	// A step turns right exactly when the walker stays in place.
	a_step_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && item_s1.mode == MODE_STEP) |=>
		((walker_q.heading == $past(walker_q.heading) + 2'd1) ==
		 (walker_q.x == $past(walker_q.x) && walker_q.y == $past(walker_q.y))))
		else $error("right turn and movement disagree");

	// The walker only changes when an item is processed.
	a_walker_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(walker_q))
		else $error("walker changed without an item");

endmodule
